// ----- rtl/iwsa_pkg.sv -----
// shared constants, codes and types of the io window section allocator
package iwsa_pkg;

    localparam int SLOT_COUNT    = 256;
    localparam int ENTRY_COUNT   = 16;
    localparam int SECTION_SHIFT = 20;

    localparam int SIDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int EIDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SUM_W   = 34;
    localparam int SECS_W  = SUM_W - SECTION_SHIFT;
    localparam int OCNT_W  = 9;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 112;
    localparam int PADDR_W     = 3;

    localparam logic [31:0] SEC_MASK        = 32'((64'd1 << SECTION_SHIFT) - 64'd1);
    localparam logic [31:0] WINDOW_BASE_RST = 32'hF000_0000;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_BASE = 1'b0;

    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_UNMAP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_NO_RUN     = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ENTRY,
        S_ESCAN,
        S_MARK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]       window;
        logic [31:0]       phys;
        logic [CNT_W-1:0]  sections;
        logic [SIDX_W-1:0] slot;
    } t_entry;

endpackage

// ----- rtl/io_window_section_allocator_unit.sv -----
// Section window allocator for device mappings.
// Items arrive on the s_axis channel: s_axis_tuser is the request kind (map or
// unmap), s_axis_tdata holds phys_addr, region_size and unmap_addr. One result
// item per request leaves on the m_axis channel.
// A map request scans the slot bitmap memory one slot per cycle (registered
// read, pipelined), then picks the lowest free entry and marks the taken
// slots one per cycle. An unmap scans the entry memory one entry per cycle
// and then frees its slots one per cycle. Zero-size, oversize and null
// requests go straight to the output state.
// The slot bitmap memory port sets the pace; one request is worked at a time.
// After reset a clearing pass frees every slot; no item is
// accepted meanwhile, configuration writes are taken as always.
// A finished result sits in an output register; the block takes the next item
// while it waits, and holds a further result back until it is taken.
// window_base is written through the apb port at address 0.
module io_window_section_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // phys_addr, region_size, unmap_addr
    input  logic [iwsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, virt_addr, window_addr, phys_base, section_count, zero fill
    output logic [iwsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iwsa_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import iwsa_pkg::*;

    t_state                 r_state, n_state;
    logic [31:0]            r_wbase;
    logic [31:0]            r_offset, n_offset;
    logic [31:0]            r_pbase, n_pbase;
    logic [31:0]            r_base, n_base;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [SIDX_W-1:0]      r_idx, n_idx;
    logic                   r_iss_on, n_iss_on;
    logic                   r_chk_v, n_chk_v;
    logic [SIDX_W-1:0]      r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]       r_run, n_run;
    logic [SIDX_W-1:0]      r_start, n_start;
    logic [SIDX_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]       r_left, n_left;
    logic                   r_mval, n_mval;
    logic [EIDX_W-1:0]      r_eiss, n_eiss;
    logic                   r_eiss_on, n_eiss_on;
    logic                   r_echk_v, n_echk_v;
    logic [EIDX_W-1:0]      r_echk, n_echk;
    logic [ENTRY_COUNT-1:0] r_valid, n_valid;
    t_status                r_st, n_st;
    logic [31:0]            r_va, n_va;
    logic [31:0]            r_win, n_win;
    logic [31:0]            r_pb, n_pb;
    logic [OCNT_W-1:0]      r_cnt, n_cnt;
    logic                   r_ov, n_ov;
    logic [OUT_TDATA_W-1:0] r_otdata, n_otdata;

    logic                   slot_we, slot_wdata, slot_rdata;
    logic [SIDX_W-1:0]      slot_waddr;
    logic                   ent_we;
    t_entry                 ent_wdata, ent_rdata;
    logic [EIDX_W-1:0]      ent_waddr;
    logic                   cfg_we;

    logic [31:0]            in_phys, in_size, in_va;
    logic [31:0]            map_offset;
    logic [SUM_W-1:0]       map_sum;
    logic [SECS_W-1:0]      map_secs;
    logic [CNT_W-1:0]       run_inc;
    logic [CNT_W-1:0]       run_start;
    logic [31:0]            map_win;
    logic                   free_any;
    logic [EIDX_W-1:0]      free_idx;

    // slot bitmap and entry table memories
    iwsa_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (r_idx),
        .o_rdata (slot_rdata)
    );

    iwsa_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRY_COUNT)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_eiss),
        .o_rdata (ent_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_WINDOW_BASE);
    assign prdata = (paddr[2] == REG_WINDOW_BASE) ? r_wbase : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbase <= WINDOW_BASE_RST;
        end else if (cfg_we) begin
            r_wbase <= pwdata;
        end
    end

    // request decode and section arithmetic
    assign in_phys    = s_axis_tdata[31:0];
    assign in_size    = s_axis_tdata[63:32];
    assign in_va      = s_axis_tdata[95:64];
    assign map_offset = in_phys & SEC_MASK;
    assign map_sum    = SUM_W'(in_size) + SUM_W'(map_offset) + SUM_W'(SEC_MASK);
    assign map_secs   = map_sum[SUM_W-1:SECTION_SHIFT];
    assign run_inc    = r_run + CNT_W'(1);
    assign run_start  = CNT_W'(r_chk_idx) + CNT_W'(1) - r_n;
    assign map_win    = r_wbase + (32'(r_start) << SECTION_SHIFT);

    // lowest free entry
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = ENTRY_COUNT - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_idx = EIDX_W'(k);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_otdata;

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_offset  = r_offset;
        n_pbase   = r_pbase;
        n_base    = r_base;
        n_n       = r_n;
        n_idx     = r_idx;
        n_iss_on  = r_iss_on;
        n_chk_v   = 1'b0;
        n_chk_idx = r_idx;
        n_run     = r_run;
        n_start   = r_start;
        n_pos     = r_pos;
        n_left    = r_left;
        n_mval    = r_mval;
        n_eiss    = r_eiss;
        n_eiss_on = r_eiss_on;
        n_echk_v  = 1'b0;
        n_echk    = r_eiss;
        n_valid   = r_valid;
        n_st      = r_st;
        n_va      = r_va;
        n_win     = r_win;
        n_pb      = r_pb;
        n_cnt     = r_cnt;
        n_ov      = r_ov & ~m_axis_tready;
        n_otdata  = r_otdata;
        slot_we    = 1'b0;
        slot_waddr = r_pos;
        slot_wdata = r_mval;
        ent_we     = 1'b0;
        ent_waddr  = free_idx;
        ent_wdata  = '{window: map_win, phys: r_pbase, sections: r_n, slot: r_start};

        unique case (r_state)
            // free every slot after reset
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_wdata = 1'b0;
                n_pos      = r_pos + SIDX_W'(1);
                if (r_pos == SIDX_W'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a request
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_st  = ST_OK;
                    n_va  = '0;
                    n_win = '0;
                    n_pb  = '0;
                    n_cnt = '0;
                    if (s_axis_tuser == REQ_MAP) begin
                        n_offset = map_offset;
                        n_pbase  = in_phys & ~SEC_MASK;
                        if (in_size == 32'd0) begin
                            n_st    = ST_ZERO_SIZE;
                            n_state = S_OUT;
                        end else if (map_secs > SECS_W'(SLOT_COUNT)) begin
                            n_st    = ST_NO_RUN;
                            n_state = S_OUT;
                        end else begin
                            n_n      = CNT_W'(map_secs);
                            n_idx    = '0;
                            n_iss_on = 1'b1;
                            n_run    = '0;
                            n_state  = S_SCAN;
                        end
                    end else begin
                        n_base = in_va & ~SEC_MASK;
                        if (in_va == 32'd0) begin
                            n_st    = ST_NOT_FOUND;
                            n_state = S_OUT;
                        end else begin
                            n_eiss    = '0;
                            n_eiss_on = 1'b1;
                            n_state   = S_ESCAN;
                        end
                    end
                end
            end
            // first-fit run search, one slot per cycle
            S_SCAN: begin
                n_chk_v = r_iss_on;
                if (r_iss_on) begin
                    n_idx = r_idx + SIDX_W'(1);
                    if (r_idx == SIDX_W'(SLOT_COUNT - 1)) begin
                        n_iss_on = 1'b0;
                    end
                end
                if (r_chk_v) begin
                    n_run = slot_rdata ? '0 : run_inc;
                    if (!slot_rdata && run_inc == r_n) begin
                        n_start = run_start[SIDX_W-1:0];
                        n_state = S_ENTRY;
                    end else if (r_chk_idx == SIDX_W'(SLOT_COUNT - 1)) begin
                        n_st    = ST_NO_RUN;
                        n_state = S_OUT;
                    end
                end
            end
            // record the mapping in the lowest free entry
            S_ENTRY: begin
                n_win = map_win;
                n_pb  = r_pbase;
                n_cnt = OCNT_W'(r_n);
                if (!free_any) begin
                    n_st    = ST_TABLE_FULL;
                    n_state = S_OUT;
                end else begin
                    ent_we            = 1'b1;
                    n_valid[free_idx] = 1'b1;
                    n_va              = map_win + r_offset;
                    n_pos             = r_start;
                    n_left            = r_n;
                    n_mval            = 1'b1;
                    n_state           = S_MARK;
                end
            end
            // entry lookup by window address, one entry per cycle
            S_ESCAN: begin
                n_echk_v = r_eiss_on;
                if (r_eiss_on) begin
                    n_eiss = r_eiss + EIDX_W'(1);
                    if (r_eiss == EIDX_W'(ENTRY_COUNT - 1)) begin
                        n_eiss_on = 1'b0;
                    end
                end
                if (r_echk_v && r_valid[r_echk] && ent_rdata.window == r_base) begin
                    n_valid[r_echk] = 1'b0;
                    n_win           = r_base;
                    n_cnt           = OCNT_W'(ent_rdata.sections);
                    n_pos           = ent_rdata.slot;
                    n_left          = ent_rdata.sections;
                    n_mval          = 1'b0;
                    n_state         = S_MARK;
                end else if (r_echk_v && r_echk == EIDX_W'(ENTRY_COUNT - 1)) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_OUT;
                end
            end
            // set or clear the run of slots
            S_MARK: begin
                slot_we = 1'b1;
                n_pos   = r_pos + SIDX_W'(1);
                n_left  = r_left - CNT_W'(1);
                if (r_left <= CNT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            // hand the result to the output register
            S_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov     = 1'b1;
                    n_otdata = {OUT_TDATA_W'(0)} |
                               OUT_TDATA_W'({r_cnt, r_pb, r_win, r_va, r_st});
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_iss_on  <= 1'b0;
            r_chk_v   <= 1'b0;
            r_eiss_on <= 1'b0;
            r_echk_v  <= 1'b0;
            r_valid   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_iss_on  <= n_iss_on;
            r_chk_v   <= n_chk_v;
            r_eiss_on <= n_eiss_on;
            r_echk_v  <= n_echk_v;
            r_valid   <= n_valid;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_offset  <= n_offset;
        r_pbase   <= n_pbase;
        r_base    <= n_base;
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_run     <= n_run;
        r_start   <= n_start;
        r_left    <= n_left;
        r_mval    <= n_mval;
        r_eiss    <= n_eiss;
        r_echk    <= n_echk;
        r_st      <= n_st;
        r_va      <= n_va;
        r_win     <= n_win;
        r_pb      <= n_pb;
        r_cnt     <= n_cnt;
        r_otdata  <= n_otdata;
    end
endmodule

// ----- rtl/iwsa_ram.sv -----
// generic single-write, single-read ram with registered read data
module iwsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
